@@ rtl/pbp_pkg.sv @@
// Shared types and constants for the pivot bucket partitioner.
`default_nettype none
package pbp_pkg;

  localparam int unsigned MaxBuckets = 16;
  localparam int unsigned NumSplit   = MaxBuckets - 1;
  localparam int unsigned BucketW    = $clog2(MaxBuckets);
  localparam int unsigned CountW     = 32;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned BlockW     = 17;
  localparam int unsigned NbW        = 5;
  localparam int unsigned AddrW      = 4;

  typedef enum logic [1:0] {
    CmdLoad   = 2'd0,
    CmdPart   = 2'd1,
    CmdFinish = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegNumBuckets  = 2'd0,
    RegWindowWords = 2'd1,
    RegBlockWords  = 2'd2,
    RegNone        = 2'd3
  } reg_e;

  typedef struct packed {
    logic load;
    logic occ;
    logic tail;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/pbp_cell.sv @@
// One splitter cell: holds a sorted splitter, compares it to the key, shifts on insert.
`default_nettype none
module pbp_cell import pbp_pkg::*; (
  input  wire logic            clk_i,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic            prev_gt_i,
  input  wire logic [KeyW-1:0] prev_val_i,
  output logic                 gt_o,
  output logic [KeyW-1:0]      val_o
);

  logic [KeyW-1:0] split_q, split_d;

  assign gt_o  = ctrl_i.occ && (split_q > key_i);
  assign val_o = split_q;

  always_comb begin
    split_d = split_q;
    if (ctrl_i.load) begin
      if (prev_gt_i) begin
        split_d = prev_val_i;
      end else if (gt_o || ctrl_i.tail) begin
        split_d = key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    split_q <= split_d;
  end

endmodule
`default_nettype wire

@@ rtl/pbp_divider.sv @@
// Radix-2 restoring divider giving the ceiling of count over block size.
`default_nettype none
module pbp_divider import pbp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CountW-1:0] dividend_i,
  input  wire logic [BlockW-1:0] divisor_i,
  output logic                   done_o,
  output logic [CountW-1:0]      ceil_o
);

  localparam int unsigned StepW = $clog2(CountW + 1);

  logic [StepW-1:0]  step_q, step_d;
  logic              done_q, done_d;
  logic [BlockW:0]   rem_q, rem_d;
  logic [CountW-1:0] quo_q, quo_d;
  logic [BlockW-1:0] div_q, div_d;
  logic [BlockW:0]   trial;

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    trial  = {rem_q[BlockW-1:0], quo_q[CountW-1]};
    if (start_i) begin
      step_d = StepW'(CountW);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = (divisor_i == '0) ? BlockW'(1) : divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - StepW'(1);
      done_d = (step_q == StepW'(1));
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[CountW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[CountW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign ceil_o = quo_q + CountW'(rem_q != '0);

endmodule
`default_nettype wire

@@ rtl/pivot_bucket_partitioner.sv @@
// Top level of the pivot bucket partitioner: splitter cell chain, fill counters, control.
// Usage:
//   Input channel (command_i, value_i, valid_i/stall_o): a request is taken when
//   valid_i is high and stall_o is low. Load requests insert a splitter into the
//   cell chain in the accepting cycle while it has room and give no result.
//   Partition requests put the routed word record in the output register after
//   StHit and StRoute once the slot is free; a following flush comes from the
//   32-step block-count divider. Finish requests step over empty buckets one a
//   cycle and flush each non-empty one. Only one request is worked on at a time;
//   stall_o is high until its last record is in the output register.
//   Output channel (kind_o .. last_o, valid_o/stall_i): one output register;
//   while stall_i is high the record holds and the block waits for the slot.
//   last_o marks the final record of a request.
//   Configuration: APB-style write port, registers at byte 0, 4, 8; pready is
//   always high. Write only while the block is idle.
//   Reset: splitter count and all fills clear, registers take 4, 65536, 512.
`default_nettype none
module pivot_bucket_partitioner import pbp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [KeyW-1:0]   value_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic                   kind_o,
  output logic [BucketW-1:0]     bucket_o,
  output logic [KeyW-1:0]        word_out_o,
  output logic [CountW-1:0]      flush_count_o,
  output logic [CountW-1:0]      flush_blocks_o,
  output logic                   last_o
);

  typedef enum logic [2:0] {
    StIdle, StHit, StRoute, StDiv, StEmit, StScan
  } state_e;

  localparam logic [CountW-1:0] CountMax = '1;

  state_e            state_q;
  logic [NbW-1:0]    nb_q;
  logic [31:0]       win_q;
  logic [BlockW-1:0] blk_q;
  logic [BucketW-1:0] cnt_q;
  logic [CountW-1:0] fill_q [MaxBuckets];
  logic [KeyW-1:0]   v_q;
  logic [BucketW-1:0] bkt_q;
  logic              scan_q;
  logic              flast_q;
  logic [CountW-1:0] fcnt_q;
  logic              out_v_q;
  logic              kind_q;
  logic [BucketW-1:0] obkt_q;
  logic [KeyW-1:0]   word_q;
  logic [CountW-1:0] ocnt_q;
  logic [CountW-1:0] oblk_q;
  logic              olast_q;

  logic [BucketW-1:0] nb_m1, active, hit_id;
  logic              hit_found;
  logic              wr_en;
  logic [1:0]        wr_idx;
  logic              accept, slot_free, do_load, out_load;
  logic [KeyW-1:0]   key;
  logic [NumSplit-1:0] gt;
  logic [KeyW-1:0]   val [NumSplit];
  logic [CountW-1:0] fill_cur, fill_new, win_eff;
  logic              need_flush;
  logic [MaxBuckets-1:0] nz, above;
  logic              div_start, div_done;
  logic [CountW-1:0] div_ceil;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign wr_idx  = paddr[3:2];

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      RegNumBuckets:  prdata = 32'(nb_q);
      RegWindowWords: prdata = win_q;
      RegBlockWords:  prdata = 32'(blk_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (nb_q < NbW'(2)) begin
      nb_m1 = BucketW'(1);
    end else if (nb_q > NbW'(MaxBuckets)) begin
      nb_m1 = BucketW'(MaxBuckets - 1);
    end else begin
      nb_m1 = BucketW'(nb_q - NbW'(1));
    end
  end
  assign active = (cnt_q < nb_m1) ? cnt_q : nb_m1;

  assign stall_o   = (state_q != StIdle);
  assign accept    = valid_i && !stall_o;
  assign slot_free = !out_v_q || !stall_i;
  assign out_load  = slot_free && ((state_q == StRoute) || (state_q == StEmit));
  assign do_load   = accept && (cmd_e'(command_i) == CmdLoad) && (cnt_q < nb_m1);
  assign key       = (state_q == StIdle) ? value_i : v_q;

  for (genvar i = 0; i < NumSplit; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.load = do_load;
    assign ctrl.occ  = (BucketW'(i) < cnt_q);
    assign ctrl.tail = (BucketW'(i) == cnt_q);
    if (i == 0) begin : g_head
      pbp_cell u_cell (
        .clk_i, .ctrl_i(ctrl), .key_i(key), .prev_gt_i(1'b0),
        .prev_val_i(key), .gt_o(gt[i]), .val_o(val[i])
      );
    end else begin : g_body
      pbp_cell u_cell (
        .clk_i, .ctrl_i(ctrl), .key_i(key), .prev_gt_i(gt[i-1]),
        .prev_val_i(val[i-1]), .gt_o(gt[i]), .val_o(val[i])
      );
    end
  end

  always_comb begin
    hit_found = 1'b0;
    hit_id    = nb_m1;
    for (int p = NumSplit - 1; p >= 0; p--) begin
      if (gt[p] && (BucketW'(p) < active)) begin
        hit_found = 1'b1;
        hit_id    = BucketW'(p);
      end
    end
  end

  for (genvar b = 0; b < MaxBuckets; b++) begin : g_nz
    assign nz[b]    = (fill_q[b] != '0);
    assign above[b] = nz[b] && (BucketW'(b) > bkt_q);
  end

  assign win_eff    = (win_q == '0) ? CountW'(1) : win_q;
  assign fill_cur   = fill_q[bkt_q];
  assign fill_new   = (fill_cur == CountMax) ? fill_cur : fill_cur + CountW'(1);
  assign need_flush = (fill_new >= win_eff) || (fill_new == CountMax);
  assign div_start  = ((state_q == StRoute) && slot_free && need_flush) ||
                      ((state_q == StScan) && nz[bkt_q]);

  pbp_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i((state_q == StRoute) ? fill_new : fill_cur),
    .divisor_i(blk_q), .done_o(div_done), .ceil_o(div_ceil)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nb_q    <= NbW'(4);
      win_q   <= 32'd65536;
      blk_q   <= BlockW'(512);
      cnt_q   <= '0;
      out_v_q <= 1'b0;
      for (int b = 0; b < MaxBuckets; b++) begin
        fill_q[b] <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (reg_e'(wr_idx))
          RegNumBuckets:  nb_q  <= pwdata[NbW-1:0];
          RegWindowWords: win_q <= pwdata;
          RegBlockWords:  blk_q <= pwdata[BlockW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !stall_i) begin
        out_v_q <= 1'b0;
      end
      if (do_load) begin
        cnt_q <= cnt_q + BucketW'(1);
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (cmd_e'(command_i))
              CmdPart:   state_q <= StHit;
              CmdFinish: state_q <= StScan;
              default:   state_q <= StIdle;
            endcase
          end
        end
        StHit: begin
          state_q <= StRoute;
        end
        StRoute: begin
          if (slot_free) begin
            fill_q[bkt_q] <= need_flush ? '0 : fill_new;
            state_q <= need_flush ? StDiv : StIdle;
          end
        end
        StScan: begin
          if (nz[bkt_q]) begin
            fill_q[bkt_q] <= '0;
            state_q <= StDiv;
          end else if (bkt_q == BucketW'(MaxBuckets - 1)) begin
            state_q <= StIdle;
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (slot_free) begin
            state_q <= (flast_q || !scan_q) ? StIdle : StScan;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        v_q    <= value_i;
        bkt_q  <= '0;
        scan_q <= (cmd_e'(command_i) == CmdFinish);
      end
      StHit: begin
        bkt_q <= hit_found ? hit_id : nb_m1;
      end
      StRoute: begin
        if (slot_free) begin
          kind_q  <= 1'b0;
          obkt_q  <= bkt_q;
          word_q  <= v_q;
          ocnt_q  <= '0;
          oblk_q  <= '0;
          olast_q <= !need_flush;
          fcnt_q  <= fill_new;
          flast_q <= 1'b1;
        end
      end
      StScan: begin
        if (nz[bkt_q]) begin
          fcnt_q  <= fill_cur;
          flast_q <= (above == '0);
        end else begin
          bkt_q <= bkt_q + BucketW'(1);
        end
      end
      StEmit: begin
        if (slot_free) begin
          kind_q  <= 1'b1;
          obkt_q  <= bkt_q;
          word_q  <= '0;
          ocnt_q  <= fcnt_q;
          oblk_q  <= div_ceil;
          olast_q <= flast_q;
          bkt_q   <= bkt_q + BucketW'(1);
        end
      end
      default: ;
    endcase
  end

  assign valid_o        = out_v_q;
  assign kind_o         = kind_q;
  assign bucket_o       = obkt_q;
  assign word_out_o     = word_q;
  assign flush_count_o  = ocnt_q;
  assign flush_blocks_o = oblk_q;
  assign last_o         = olast_q;

endmodule
`default_nettype wire
